// File: sv/rfp_pkg.sv
// Shared widths, constants, tables and types of the Robinson forward projection.
package rfp_pkg;

  localparam int FRAC_BITS = 16;
  localparam int T_BITS = 20;

  localparam int LAT_W = 25;
  localparam int LON_W = 26;
  localparam int CENTER_W = 25;
  localparam int RADIUS_W = 27;
  localparam int X_W = 32;
  localparam int Y_W = 29;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W = 27;

  localparam logic [RADIUS_W-1:0] RADIUS_RESET = 27'd6378137;

  localparam int BAND_STAGES = 3;
  localparam int INTERP_STAGES = 5;
  localparam int SCALE_STAGES = 4;
  localparam int NUM_STAGES = BAND_STAGES + INTERP_STAGES + SCALE_STAGES;

  localparam int ABS_W = LAT_W;
  localparam int HI_W = ABS_W - FRAC_BITS;
  localparam int BAND_W = 6;
  localparam int LAST_BAND = 17;
  localparam int BAND_DIV = 5;
  localparam int BAND_D = BAND_DIV << FRAC_BITS;
  localparam int BAND_RECIP = 205;
  localparam int BAND_RECIP_SH = 10;
  localparam int BP_W = HI_W + 8;
  localparam int FNUM_W = FRAC_BITS + 3;

  localparam int M_W = FNUM_W + T_BITS - FRAC_BITS;
  localparam int T_ROUND = 2;
  localparam int RECIP5 = 6710887;
  localparam int RECIP5_W = 23;
  localparam int RECIP5_SH = 25;
  localparam int TP_W = M_W + RECIP5_W;
  localparam int T_W = T_BITS + 1;

  localparam int TAB_W = 18;
  localparam int DIFF_W = TAB_W + 1;
  localparam int D2_W = TAB_W + 2;
  localparam int P1_W = T_W + 1 + DIFF_W;
  localparam int Q_W = 2 * T_W + 1 + D2_W;
  localparam int NUM_W = 64;
  localparam int INTERP_T2_SH = 41;
  localparam int INTERP_RND_SH = 33;
  localparam int MAG_W = 27;
  localparam int NUM_TBL = 2;

  localparam int DLON_W = 27;
  localparam int DMAG_W = 26;
  localparam int KX_W = 26;
  localparam int KY_W = 33;
  localparam logic [KX_W-1:0] KX_Q32 = 26'd63619673;
  localparam logic [KY_W-1:0] KY_Q32 = 33'd5808084274;

  // x magnitude product is split into SPLIT-bit halves; PA_W equals 2*SPLIT
  localparam int SPLIT = 26;
  localparam int PA_W = DMAG_W + KX_W;
  localparam int PB_W = RADIUS_W + MAG_W;
  localparam int PPX_W = PB_W;
  localparam int PPY_W = PB_W - SPLIT + KY_W;
  localparam int X_SHIFT = FRAC_BITS + 56;
  localparam int Y_SHIFT = 56;
  localparam int XSUM_W = PA_W + PB_W + 1;
  localparam int XM_W = XSUM_W - X_SHIFT;
  localparam int YSUM_W = PB_W + KY_W + 1;
  localparam int YM_W = YSUM_W - Y_SHIFT;
  localparam int Y_SAT = 268435455;

  localparam int ROM_DEPTH = 20;
  localparam int ROM_IDX_W = 5;

  localparam logic signed [TAB_W-1:0] PDIST_ROM [ROM_DEPTH] = '{
    -18'sd4063, 18'sd0, 18'sd4063, 18'sd8126, 18'sd12190,
    18'sd16253, 18'sd20316, 18'sd24379, 18'sd28443, 18'sd32493,
    18'sd36510, 18'sd40475, 18'sd44361, 18'sd48143, 18'sd51793,
    18'sd55280, 18'sd58563, 18'sd61565, 18'sd63970, 18'sd65536
  };

  localparam logic signed [TAB_W-1:0] PLEN_ROM [ROM_DEPTH] = '{
    18'sd65444, 18'sd65536, 18'sd65444, 18'sd65235, 18'sd64881,
    18'sd64369, 18'sd63767, 18'sd62915, 18'sd61781, 18'sd60398,
    18'sd58733, 18'sd56879, 18'sd54723, 18'sd52337, 18'sd49788,
    18'sd47094, 18'sd44119, 18'sd40718, 18'sd37500, 18'sd34878
  };

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_CENTER_LONGITUDE  = 2'd0,
    REG_EQUATORIAL_RADIUS = 2'd1,
    REG_POSITIVE_WEST     = 2'd2
  } reg_index_t;

  typedef enum logic {
    TBL_PDIST = 1'b0,
    TBL_PLEN  = 1'b1
  } tbl_t;

  typedef struct packed {
    logic [DMAG_W-1:0] dlon_mag;
    logic              dlon_neg;
    logic              lat_neg;
    logic              beyond;
  } side_t;

  typedef struct packed {
    logic [MAG_W-1:0] mag;
    logic             neg;
  } q24_t;

  function automatic logic signed [TAB_W-1:0] rom_value(input tbl_t tbl,
                                                       input logic [BAND_W-1:0] idx);
    logic signed [TAB_W-1:0] val;
    val = '0;
    if (idx < BAND_W'(ROM_DEPTH)) begin
      case (tbl)
        TBL_PLEN:  val = PLEN_ROM[idx[ROM_IDX_W-1:0]];
        TBL_PDIST: val = PDIST_ROM[idx[ROM_IDX_W-1:0]];
        default:   val = '0;
      endcase
    end
    return val;
  endfunction

endpackage

// File: sv/rfp_band.sv
// Latitude magnitude, 5-degree band, fraction and longitude offset stages.
module rfp_band import rfp_pkg::*; (
  input  logic                       clk,
  input  logic [BAND_STAGES-1:0]     en,
  input  logic signed [LAT_W-1:0]    latitude,
  input  logic signed [LON_W-1:0]    longitude,
  input  logic signed [CENTER_W-1:0] center_longitude,
  input  logic                       positive_west,
  output logic [T_W-1:0]             t,
  output logic [BAND_W-1:0]          band,
  output side_t                      side
);

  logic [ABS_W-1:0]         abs_c;
  logic signed [DLON_W-1:0] lon_x;
  logic signed [DLON_W-1:0] ctr_x;
  logic signed [DLON_W-1:0] dlon_c;
  logic [DMAG_W-1:0]        dmag_c;

  logic [ABS_W-1:0]  abs0;
  logic              lat_neg0;
  logic [DMAG_W-1:0] dmag0;
  logic              dneg0;

  logic [ABS_W-1:0]  am1;
  logic [HI_W-1:0]   hi;
  logic [BP_W-1:0]   bprod;
  logic [BAND_W-1:0] band_c;
  logic [FNUM_W-1:0] fnum_c;

  logic [BAND_W-1:0] band1;
  logic [FNUM_W-1:0] fnum1;
  side_t             side1;

  logic [M_W-1:0]  m_c;
  logic [TP_W-1:0] tprod;

  assign abs_c  = latitude[LAT_W-1] ? ABS_W'(-latitude) : ABS_W'(latitude);
  assign lon_x  = DLON_W'(longitude);
  assign ctr_x  = DLON_W'(center_longitude);
  assign dlon_c = positive_west ? (ctr_x - lon_x) : (lon_x - ctr_x);
  assign dmag_c = dlon_c[DLON_W-1] ? DMAG_W'(-dlon_c) : DMAG_W'(dlon_c);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      abs0     <= abs_c;
      lat_neg0 <= latitude[LAT_W-1];
      dmag0    <= dmag_c;
      dneg0    <= dlon_c[DLON_W-1];
    end
  end

  // band = (a - 1) / D, with a zero latitude in band zero
  assign am1    = abs0 - ABS_W'(1);
  assign hi     = am1[ABS_W-1:FRAC_BITS];
  assign bprod  = BP_W'(hi) * BP_W'(BAND_RECIP);
  assign band_c = (abs0 == '0) ? '0 : BAND_W'(bprod >> BAND_RECIP_SH);
  assign fnum_c = FNUM_W'(abs0 - ABS_W'(band_c) * ABS_W'(BAND_D));

  always_ff @(posedge clk) begin
    if (en[1]) begin
      band1          <= band_c;
      fnum1          <= fnum_c;
      side1.dlon_mag <= dmag0;
      side1.dlon_neg <= dneg0;
      side1.lat_neg  <= lat_neg0;
      side1.beyond   <= band_c > BAND_W'(LAST_BAND);
    end
  end

  // t = round(fnum * 2^T_BITS / D) as a reciprocal multiply
  assign m_c   = (M_W'(fnum1) << (T_BITS - FRAC_BITS)) + M_W'(T_ROUND);
  assign tprod = TP_W'(m_c) * TP_W'(RECIP5);

  always_ff @(posedge clk) begin
    if (en[2]) begin
      t    <= T_W'(tprod >> RECIP5_SH);
      band <= band1;
      side <= side1;
    end
  end

endmodule

// File: sv/rfp_interp.sv
// Table lookup and central second-difference interpolation of both tables.
module rfp_interp import rfp_pkg::*; (
  input  logic                     clk,
  input  logic [INTERP_STAGES-1:0] en,
  input  logic [T_W-1:0]           t,
  input  logic [BAND_W-1:0]        band,
  output q24_t                     plen,
  output q24_t                     pdist
);

  logic [T_W-1:0]   t3;
  logic [2*T_W-1:0] tt4;

  logic signed [TAB_W-1:0] r1 [NUM_TBL];
  logic signed [TAB_W-1:0] r2 [NUM_TBL];
  logic signed [TAB_W-1:0] r3 [NUM_TBL];
  logic signed [P1_W-1:0]  p1_4 [NUM_TBL];
  logic signed [D2_W-1:0]  d2_4 [NUM_TBL];
  logic signed [TAB_W-1:0] t2_4 [NUM_TBL];
  logic signed [Q_W-1:0]   q5 [NUM_TBL];
  logic signed [P1_W-1:0]  p1_5 [NUM_TBL];
  logic signed [TAB_W-1:0] t2_5 [NUM_TBL];
  logic signed [NUM_W-1:0] num6 [NUM_TBL];
  logic [NUM_W-1:0]        absn [NUM_TBL];
  logic [NUM_W-1:0]        rnd [NUM_TBL];
  q24_t                    res [NUM_TBL];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      t3 <= t;
      for (int k = 0; k < NUM_TBL; k++) begin
        r1[k] <= rom_value(tbl_t'(k), band);
        r2[k] <= rom_value(tbl_t'(k), BAND_W'(band + BAND_W'(1)));
        r3[k] <= rom_value(tbl_t'(k), BAND_W'(band + BAND_W'(2)));
      end
    end
    if (en[1]) begin
      tt4 <= (2*T_W)'(t3) * (2*T_W)'(t3);
      for (int k = 0; k < NUM_TBL; k++) begin
        p1_4[k] <= signed'({1'b0, t3}) * (r3[k] - r1[k]);
        d2_4[k] <= D2_W'(r3[k]) + D2_W'(r1[k]) - (D2_W'(r2[k]) <<< 1);
        t2_4[k] <= r2[k];
      end
    end
    if (en[2]) begin
      for (int k = 0; k < NUM_TBL; k++) begin
        q5[k]   <= signed'({1'b0, tt4}) * d2_4[k];
        p1_5[k] <= p1_4[k];
        t2_5[k] <= t2_4[k];
      end
    end
    if (en[3]) begin
      for (int k = 0; k < NUM_TBL; k++) begin
        num6[k] <= (NUM_W'(t2_5[k]) <<< INTERP_T2_SH) + (NUM_W'(p1_5[k]) <<< T_BITS)
                 + NUM_W'(q5[k]);
      end
    end
    if (en[4]) begin
      for (int k = 0; k < NUM_TBL; k++) begin
        res[k].mag <= MAG_W'(rnd[k]);
        res[k].neg <= num6[k][NUM_W-1];
      end
    end
  end

  // round magnitude to Q24, halves away from zero
  always_comb begin
    for (int k = 0; k < NUM_TBL; k++) begin
      absn[k] = num6[k][NUM_W-1] ? NUM_W'(-num6[k]) : NUM_W'(num6[k]);
      rnd[k]  = (absn[k] + (NUM_W'(1) << (INTERP_RND_SH - 1))) >> INTERP_RND_SH;
    end
  end

  assign plen  = res[TBL_PLEN];
  assign pdist = res[TBL_PDIST];

endmodule

// File: sv/rfp_scale.sv
// Radius and constant scaling, partial products, rounding and saturation to metres.
module rfp_scale import rfp_pkg::*; (
  input  logic                    clk,
  input  logic [SCALE_STAGES-1:0] en,
  input  logic [RADIUS_W-1:0]     equatorial_radius,
  input  q24_t                    plen,
  input  q24_t                    pdist,
  input  side_t                   side,
  output logic signed [X_W-1:0]   x_coord,
  output logic signed [Y_W-1:0]   y_coord,
  output logic                    ok
);

  localparam logic [XM_W-1:0] X_NEG_LIM = XM_W'(64'd1 << (X_W - 1));
  localparam logic [XM_W-1:0] X_POS_LIM = X_NEG_LIM - XM_W'(1);
  localparam logic [X_W-1:0]  X_MAX = {1'b0, {(X_W-1){1'b1}}};
  localparam logic [X_W-1:0]  X_MIN = {1'b1, {(X_W-1){1'b0}}};

  logic [PA_W-1:0] pa8;
  logic [PB_W-1:0] pb8;
  logic [PB_W-1:0] pc8;
  logic            xneg8;
  logic            yneg8;
  logic            beyond8;

  logic [PPX_W-1:0] p00;
  logic [PPX_W-1:0] p01;
  logic [PPX_W-1:0] p10;
  logic [PPX_W-1:0] p11;
  logic [PPY_W-1:0] q0;
  logic [PPY_W-1:0] q1;
  logic             xneg9;
  logic             yneg9;
  logic             beyond9;

  logic [XSUM_W-1:0] xsum_c;
  logic [YSUM_W-1:0] ysum_c;
  logic [XM_W-1:0]   xm10;
  logic [YM_W-1:0]   ym10;
  logic              xneg10;
  logic              yneg10;
  logic              beyond10;

  logic [X_W-1:0]  x_c;
  logic [YM_W-1:0] ys_c;
  logic [Y_W-1:0]  y_c;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      pa8     <= PA_W'(side.dlon_mag) * PA_W'(KX_Q32);
      pb8     <= PB_W'(equatorial_radius) * PB_W'(plen.mag);
      pc8     <= PB_W'(equatorial_radius) * PB_W'(pdist.mag);
      xneg8   <= side.dlon_neg ^ plen.neg;
      yneg8   <= side.lat_neg ^ pdist.neg;
      beyond8 <= side.beyond;
    end
    if (en[1]) begin
      p00     <= PPX_W'(pa8[SPLIT-1:0]) * PPX_W'(pb8[SPLIT-1:0]);
      p01     <= PPX_W'(pa8[SPLIT-1:0]) * PPX_W'(pb8[PB_W-1:SPLIT]);
      p10     <= PPX_W'(pa8[PA_W-1:SPLIT]) * PPX_W'(pb8[SPLIT-1:0]);
      p11     <= PPX_W'(pa8[PA_W-1:SPLIT]) * PPX_W'(pb8[PB_W-1:SPLIT]);
      q0      <= PPY_W'(pc8[SPLIT-1:0]) * PPY_W'(KY_Q32);
      q1      <= PPY_W'(pc8[PB_W-1:SPLIT]) * PPY_W'(KY_Q32);
      xneg9   <= xneg8;
      yneg9   <= yneg8;
      beyond9 <= beyond8;
    end
    if (en[2]) begin
      xm10     <= XM_W'(xsum_c >> X_SHIFT);
      ym10     <= YM_W'(ysum_c >> Y_SHIFT);
      xneg10   <= xneg9;
      yneg10   <= yneg9;
      beyond10 <= beyond9;
    end
    if (en[3]) begin
      x_coord <= beyond10 ? '0 : x_c;
      y_coord <= beyond10 ? '0 : y_c;
      ok      <= ~beyond10;
    end
  end

  assign xsum_c = (XSUM_W'(p11) << (2 * SPLIT))
                + ((XSUM_W'(p01) + XSUM_W'(p10)) << SPLIT)
                + XSUM_W'(p00)
                + (XSUM_W'(1) << (X_SHIFT - 1));
  assign ysum_c = (YSUM_W'(q1) << SPLIT) + YSUM_W'(q0) + (YSUM_W'(1) << (Y_SHIFT - 1));

  always_comb begin
    if (xneg10) begin
      x_c = (xm10 > X_NEG_LIM) ? X_MIN : X_W'(XM_W'(0) - xm10);
    end else begin
      x_c = (xm10 > X_POS_LIM) ? X_MAX : X_W'(xm10);
    end
    ys_c = (ym10 > YM_W'(Y_SAT)) ? YM_W'(Y_SAT) : ym10;
    y_c  = yneg10 ? Y_W'(YM_W'(0) - ys_c) : Y_W'(ys_c);
  end

endmodule

// File: sv/robinson_forward_projection_top.sv
// Top level of the Robinson forward projection pipeline.
// One latitude/longitude item enters per clock while in_stall is low; the rate of one
// item per cycle comes from the twelve-stage pipeline (3 band and fraction stages, 5
// table interpolation stages, 4 scaling stages), whose longest steps are the 26 by 28
// bit partial products and the 107-bit rounding sum of the x scaling. A stalled output
// holds the last stage and each full stage behind it up to the first empty one; empty
// stages upstream keep filling, so the input stalls only when all twelve stages hold an
// item. Configuration writes are always ready; the center and direction apply to
// items accepted after them, the radius to every item not yet in the scaling
// stages, so write them while the pipeline is empty. The parallel length and
// distance tables are constants, so no loading or clearing pass follows reset.
module robinson_forward_projection_top import rfp_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [LAT_W-1:0]   latitude,
  input  logic signed [LON_W-1:0]   longitude,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [X_W-1:0]     x_coord,
  output logic signed [Y_W-1:0]     y_coord,
  output logic                      ok,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data
);

  logic signed [CENTER_W-1:0] center_longitude;
  logic [RADIUS_W-1:0]        equatorial_radius;
  logic                       positive_west;

  logic [NUM_STAGES-1:0] v;
  logic [NUM_STAGES-1:0] en;

  logic [T_W-1:0]    band_t;
  logic [BAND_W-1:0] band_idx;
  side_t             band_side;
  side_t             side_q [INTERP_STAGES];
  q24_t              plen;
  q24_t              pdist;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_longitude  <= '0;
      equatorial_radius <= RADIUS_RESET;
      positive_west     <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_index_t'(cfg_index))
        REG_CENTER_LONGITUDE:  center_longitude <= cfg_data[CENTER_W-1:0];
        REG_EQUATORIAL_RADIUS: equatorial_radius <= cfg_data[RADIUS_W-1:0];
        REG_POSITIVE_WEST:     positive_west <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // advance a stage when it is empty or the next one advances
  assign en[NUM_STAGES-1] = ~v[NUM_STAGES-1] | ~out_stall;
  for (genvar s = 0; s < NUM_STAGES - 1; s++) begin : g_en
    assign en[s] = ~v[s] | en[s+1];
  end

  assign in_stall  = ~en[0];
  assign out_valid = v[NUM_STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= in_valid;
      end
      for (int s = 1; s < NUM_STAGES; s++) begin
        if (en[s]) begin
          v[s] <= v[s-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[BAND_STAGES]) begin
      side_q[0] <= band_side;
    end
    for (int i = 1; i < INTERP_STAGES; i++) begin
      if (en[BAND_STAGES + i]) begin
        side_q[i] <= side_q[i-1];
      end
    end
  end

  rfp_band u_band (
    .clk              (clk),
    .en               (en[BAND_STAGES-1:0]),
    .latitude         (latitude),
    .longitude        (longitude),
    .center_longitude (center_longitude),
    .positive_west    (positive_west),
    .t                (band_t),
    .band             (band_idx),
    .side             (band_side)
  );

  rfp_interp u_interp (
    .clk   (clk),
    .en    (en[BAND_STAGES+INTERP_STAGES-1:BAND_STAGES]),
    .t     (band_t),
    .band  (band_idx),
    .plen  (plen),
    .pdist (pdist)
  );

  rfp_scale u_scale (
    .clk               (clk),
    .en                (en[NUM_STAGES-1:BAND_STAGES+INTERP_STAGES]),
    .equatorial_radius (equatorial_radius),
    .plen              (plen),
    .pdist             (pdist),
    .side              (side_q[INTERP_STAGES-1]),
    .x_coord           (x_coord),
    .y_coord           (y_coord),
    .ok                (ok)
  );

  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    ((&v) && out_stall) |-> in_stall)
    else $error("item accepted into a full stalled pipeline");

  a_beyond_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !ok) |-> (x_coord == '0 && y_coord == '0))
    else $error("out-of-table item with nonzero coordinates");

  a_y_sat: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (y_coord != {1'b1, {(Y_W-1){1'b0}}}))
    else $error("y coordinate beyond its saturation limit");

endmodule
